FILE: hdl/vclru_pkg.sv
// ----------------------------------------------------------------------------
// vclru_pkg
// Shared types, constants and helpers of the victim cache LRU table.
// ----------------------------------------------------------------------------
package vclru_pkg;

  localparam int ENTRIES   = 16;
  localparam int CORES     = 2;
  localparam int ADDR_BITS = 48;

  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W     = IDX_W;
  localparam int HELD_W     = $clog2(ENTRIES + 1);
  localparam int CORE_IDX_W = (CORES > 1) ? $clog2(CORES) : 1;

  localparam int FIELD_ADDR_W = 48;
  localparam int CAP_W        = 5;
  localparam int SHIFT_W      = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd5;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd6;

  localparam logic [1:0] MODE_TAKE    = 2'd0;
  localparam logic [1:0] MODE_PEEK    = 2'd1;
  localparam logic [1:0] MODE_INSTALL = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic [IDX_W-1:0] first_idx(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: hdl/vclru_ctrl.sv
// ----------------------------------------------------------------------------
// vclru_ctrl
// Request sequencer: accept, look up, then commit into the result register.
// ----------------------------------------------------------------------------
module vclru_ctrl import vclru_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/vclru_dp.sv
// ----------------------------------------------------------------------------
// vclru_dp
// Line stores, associative match, LRU rank update and result register.
// ----------------------------------------------------------------------------
module vclru_dp import vclru_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]              mode,
  input  logic                    core,
  input  logic [47:0]             addr,
  input  logic                    dirty,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic                    hit_dirty,
  output logic                    evicted,
  output logic [FIELD_ADDR_W-1:0] victim_addr,
  output logic                    victim_dirty
);

  logic               enable;
  logic [CAP_W-1:0]   capacity;
  logic [SHIFT_W-1:0] offset_bits;

  logic                 line_valid   [CORES][ENTRIES];
  logic                 line_dirty   [CORES][ENTRIES];
  logic [RANK_W-1:0]    lru_rank     [CORES][ENTRIES];
  logic [ADDR_BITS-1:0] line_address [CORES][ENTRIES];
  logic [HELD_W-1:0]    lines_held   [CORES];

  logic [1:0]           req_mode;
  logic                 req_core;
  logic [ADDR_BITS-1:0] req_addr;
  logic                 req_dirty;

  logic             s_hit, v_found, full;
  logic [IDX_W-1:0] s_idx, v_idx;

  logic [CORE_IDX_W-1:0] c;
  logic                  core_ok;
  logic [ADDR_BITS-1:0]  key;
  logic [ENTRIES-1:0]    match_v, lru_v;
  logic [CAP_W-1:0]      cap_eff;
  logic [HELD_W-1:0]     held_c;

  logic                  row_valid_n [ENTRIES];
  logic                  row_dirty_n [ENTRIES];
  logic [RANK_W-1:0]     row_rank_n  [ENTRIES];
  logic [HELD_W-1:0]     held_n;
  logic                  addr_we;
  logic [IDX_W-1:0]      addr_idx;
  logic                  o_hit, o_hd, o_ev, o_evd;
  logic [ADDR_BITS-1:0]  o_eva;

  logic [ENTRIES-1:0]    free_v;
  logic [RANK_W-1:0]     r_s, r_v;
  logic                  active;

  assign c       = CORE_IDX_W'(req_core);
  assign core_ok = 32'(req_core) < CORES;
  assign active  = enable && core_ok;
  assign key     = req_addr & ({ADDR_BITS{1'b1}} << offset_bits);
  assign held_c  = lines_held[c];

  always_comb begin
    if (capacity == '0)               cap_eff = CAP_W'(1);
    else if (32'(capacity) > ENTRIES) cap_eff = CAP_W'(ENTRIES);
    else                              cap_eff = capacity;
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_v[i] = line_valid[c][i] && (line_address[c][i] == key);
      lru_v[i]   = line_valid[c][i] && (held_c != '0) &&
                   (lru_rank[c][i] == RANK_W'(held_c - HELD_W'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      capacity    <= CAP_RESET;
      offset_bits <= SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:      enable      <= cfg_data[0];
        CFG_CAPACITY:    capacity    <= cfg_data[CAP_W-1:0];
        CFG_OFFSET_BITS: offset_bits <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode  <= mode;
      req_core  <= core;
      req_addr  <= ADDR_BITS'(addr);
      req_dirty <= dirty;
    end
    if (cmd.lookup) begin
      s_hit   <= |match_v;
      s_idx   <= first_idx(match_v);
      v_found <= |lru_v;
      v_idx   <= first_idx(lru_v);
      full    <= 32'(held_c) >= 32'(cap_eff);
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      row_valid_n[i] = line_valid[c][i];
      row_dirty_n[i] = line_dirty[c][i];
      row_rank_n[i]  = lru_rank[c][i];
    end
    held_n   = held_c;
    addr_we  = 1'b0;
    addr_idx = '0;
    free_v   = '0;
    o_hit    = 1'b0;
    o_hd     = 1'b0;
    o_ev     = 1'b0;
    o_evd    = 1'b0;
    o_eva    = '0;
    r_s      = lru_rank[c][s_idx];
    r_v      = lru_rank[c][v_idx];
    case (req_mode)
      MODE_TAKE: begin
        if (s_hit) begin
          o_hit = 1'b1;
          o_hd  = line_dirty[c][s_idx];
          for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[c][i] && lru_rank[c][i] > r_s)
              row_rank_n[i] = lru_rank[c][i] - RANK_W'(1);
          end
          row_valid_n[s_idx] = 1'b0;
          row_dirty_n[s_idx] = 1'b0;
          row_rank_n[s_idx]  = '0;
          if (held_c != '0) held_n = held_c - HELD_W'(1);
        end
      end
      MODE_PEEK: begin
        if (!s_hit && full && v_found) begin
          o_ev  = 1'b1;
          o_eva = line_address[c][v_idx];
          o_evd = line_dirty[c][v_idx];
        end
      end
      MODE_INSTALL: begin
        if (s_hit) begin
          o_hit = 1'b1;
          row_dirty_n[s_idx] = line_dirty[c][s_idx] | req_dirty;
          for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[c][i] && lru_rank[c][i] < r_s)
              row_rank_n[i] = lru_rank[c][i] + RANK_W'(1);
          end
          row_rank_n[s_idx] = '0;
        end else begin
          if (full && v_found) begin
            o_ev  = 1'b1;
            o_eva = line_address[c][v_idx];
            o_evd = line_dirty[c][v_idx];
            for (int i = 0; i < ENTRIES; i++) begin
              if (line_valid[c][i] && lru_rank[c][i] > r_v)
                row_rank_n[i] = lru_rank[c][i] - RANK_W'(1);
            end
            row_valid_n[v_idx] = 1'b0;
            row_dirty_n[v_idx] = 1'b0;
            row_rank_n[v_idx]  = '0;
            if (held_c != '0) held_n = held_c - HELD_W'(1);
          end
          for (int i = 0; i < ENTRIES; i++) free_v[i] = !row_valid_n[i];
          if (|free_v) begin
            addr_we  = 1'b1;
            addr_idx = first_idx(free_v);
            for (int i = 0; i < ENTRIES; i++) begin
              if (row_valid_n[i]) row_rank_n[i] = row_rank_n[i] + RANK_W'(1);
            end
            row_valid_n[addr_idx] = 1'b1;
            row_dirty_n[addr_idx] = req_dirty;
            row_rank_n[addr_idx]  = '0;
            held_n = held_n + HELD_W'(1);
          end
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          row_valid_n[i] = 1'b0;
          row_dirty_n[i] = 1'b0;
          row_rank_n[i]  = '0;
        end
        held_n = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CORES; k++) begin
        lines_held[k] <= '0;
        for (int i = 0; i < ENTRIES; i++) begin
          line_valid[k][i] <= 1'b0;
          line_dirty[k][i] <= 1'b0;
          lru_rank[k][i]   <= '0;
        end
      end
    end else if (cmd.commit && active) begin
      lines_held[c] <= held_n;
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[c][i] <= row_valid_n[i];
        line_dirty[c][i] <= row_dirty_n[i];
        lru_rank[c][i]   <= row_rank_n[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && active && addr_we && req_mode == MODE_INSTALL)
      line_address[c][addr_idx] <= key;
  end

  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= active & o_hit;
      hit_dirty    <= active & o_hd;
      evicted      <= active & o_ev;
      victim_addr  <= active ? FIELD_ADDR_W'(o_eva) : '0;
      victim_dirty <= active & o_evd;
    end
  end

endmodule

FILE: hdl/victim_cache_lru_table_core.sv
// ----------------------------------------------------------------------------
// victim_cache_lru_table_core
// Per-core fully associative victim line table kept in LRU order.
// ----------------------------------------------------------------------------
// Sequence: accept, match in the lookup state, then commit into the result
// register, which waits while the held result is stalled; no new request is
// taken before commit; the next is taken while the result waits downstream.
// Reset: synchronous, clears all valid, dirty and rank state and line counts;
// registers return to enable 0, capacity 5, offset bits 6.
module victim_cache_lru_table_core import vclru_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              mode,
  input  logic                    core,
  input  logic [47:0]             addr,
  input  logic                    dirty,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit,
  output logic                    hit_dirty,
  output logic                    evicted,
  output logic [FIELD_ADDR_W-1:0] victim_addr,
  output logic                    victim_dirty
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vclru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vclru_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .core         (core),
    .addr         (addr),
    .dirty        (dirty),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .hit_dirty    (hit_dirty),
    .evicted      (evicted),
    .victim_addr  (victim_addr),
    .victim_dirty (victim_dirty)
  );

endmodule

FILE: sim/victim_cache_lru_table_checker.sv
// ----------------------------------------------------------------------------
// victim_cache_lru_table_checker
// Watches the request, result and register ports of the victim line table.
// It keeps its own per-core copy of the LRU line store and the registers,
// works out the result of every accepted request, and compares each accepted
// result field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module victim_cache_lru_table_checker import vclru_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              mode,
  input  logic                    core,
  input  logic [47:0]             addr,
  input  logic                    dirty,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    hit,
  input  logic                    hit_dirty,
  input  logic                    evicted,
  input  logic [FIELD_ADDR_W-1:0] victim_addr,
  input  logic                    victim_dirty,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic        hit;
    logic        hit_dirty;
    logic        evicted;
    logic [47:0] victim_addr;
    logic        victim_dirty;
  } victim_result_t;

  logic               enabled;
  logic [CAP_W-1:0]   capacity;
  logic [SHIFT_W-1:0] offset_bits;

  logic              slot_valid [CORES][ENTRIES];
  logic [47:0]       slot_line  [CORES][ENTRIES];
  logic              slot_dirty [CORES][ENTRIES];
  logic [RANK_W-1:0] slot_rank  [CORES][ENTRIES];
  logic [HELD_W-1:0] lines_held [CORES];

  victim_result_t expected_q [$];

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  function automatic void wipe_core(input int c);
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[c][i] = 1'b0;
      slot_line[c][i]  = '0;
      slot_dirty[c][i] = 1'b0;
      slot_rank[c][i]  = '0;
    end
    lines_held[c] = '0;
  endfunction

  function automatic int lru_slot(input int c);
    if (lines_held[c] == 0) return -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[c][i] && int'(slot_rank[c][i]) == int'(lines_held[c]) - 1) return i;
    return -1;
  endfunction

  function automatic void drop_slot(input int c, input int s);
    logic [RANK_W-1:0] r;
    r = slot_rank[c][s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[c][i] && slot_rank[c][i] > r) slot_rank[c][i]--;
    slot_valid[c][s] = 1'b0;
    slot_dirty[c][s] = 1'b0;
    slot_rank[c][s]  = '0;
    if (lines_held[c] > 0) lines_held[c]--;
  endfunction

  function automatic victim_result_t lookup_victim(input logic [1:0] m, input logic cr,
                                                   input logic [47:0] a, input logic d);
    victim_result_t r;
    logic [47:0] key;
    logic [RANK_W-1:0] rk;
    int c, found, victim, free_slot, cap;
    r = '0;
    c = int'(cr);
    if (!enabled || c >= CORES) return r;
    key = (a >> offset_bits) << offset_bits;
    cap = (capacity == 0) ? 1 : ((int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity));
    found = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (slot_valid[c][i] && slot_line[c][i] == key) found = i;
    case (m)
      MODE_TAKE: begin
        if (found >= 0) begin
          r.hit       = 1'b1;
          r.hit_dirty = slot_dirty[c][found];
          drop_slot(c, found);
        end
      end
      MODE_PEEK: begin
        if (found < 0 && int'(lines_held[c]) >= cap) begin
          victim = lru_slot(c);
          if (victim >= 0) begin
            r.evicted      = 1'b1;
            r.victim_addr  = slot_line[c][victim];
            r.victim_dirty = slot_dirty[c][victim];
          end
        end
      end
      MODE_INSTALL: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          slot_dirty[c][found] = slot_dirty[c][found] | d;
          rk = slot_rank[c][found];
          for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[c][i] && slot_rank[c][i] < rk) slot_rank[c][i]++;
          slot_rank[c][found] = '0;
        end else begin
          if (int'(lines_held[c]) >= cap) begin
            victim = lru_slot(c);
            if (victim >= 0) begin
              r.evicted      = 1'b1;
              r.victim_addr  = slot_line[c][victim];
              r.victim_dirty = slot_dirty[c][victim];
              drop_slot(c, victim);
            end
          end
          free_slot = -1;
          for (int i = ENTRIES - 1; i >= 0; i--)
            if (!slot_valid[c][i]) free_slot = i;
          if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
              if (slot_valid[c][i]) slot_rank[c][i]++;
            slot_valid[c][free_slot] = 1'b1;
            slot_line[c][free_slot]  = key;
            slot_dirty[c][free_slot] = d;
            slot_rank[c][free_slot]  = '0;
            lines_held[c]++;
          end
        end
      end
      default: wipe_core(c);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    victim_result_t want;
    if (rst) begin
      enabled     = 1'b0;
      capacity    = CAP_RESET;
      offset_bits = SHIFT_RESET;
      for (int c = 0; c < CORES; c++) wipe_core(c);
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request outstanding", 48'd1, 48'd0);
        end else begin
          want = expected_q.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (hit_dirty !== want.hit_dirty)
            report_mismatch("hit_dirty", hit_dirty, want.hit_dirty);
          if (evicted !== want.evicted) report_mismatch("evicted", evicted, want.evicted);
          if (victim_addr !== want.victim_addr)
            report_mismatch("victim_addr", victim_addr, want.victim_addr);
          if (victim_dirty !== want.victim_dirty)
            report_mismatch("victim_dirty", victim_dirty, want.victim_dirty);
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(lookup_victim(mode, core, addr, dirty));
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:      enabled     = cfg_data[0];
          CFG_CAPACITY:    capacity    = cfg_data[CAP_W-1:0];
          CFG_OFFSET_BITS: offset_bits = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: sim/tb_victim_cache_lru_table_core.sv
// ----------------------------------------------------------------------------
// tb_victim_cache_lru_table_core
// Drives the victim line table with a directed LRU sequence and then random
// take, peek, install and clear requests over a pool of lines, across several
// register settings including disabled, out-of-range capacity and wide line
// shifts. Both ports idle at random; the result side holds off once for a
// long stretch. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_victim_cache_lru_table_core;
  import vclru_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int POOL_LINES  = 20;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 8;

  localparam logic [47:0] LINE_A = 48'h0000_1234_5640;
  localparam logic [47:0] LINE_B = 48'h7fff_0000_0080;
  localparam logic [47:0] LINE_C = 48'h8000_abcd_ef00;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_ENABLE;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              mode = MODE_TAKE;
  logic                    core = 1'b0;
  logic [47:0]             addr = '0;
  logic                    dirty = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    hit;
  logic                    hit_dirty;
  logic                    evicted;
  logic [FIELD_ADDR_W-1:0] victim_addr;
  logic                    victim_dirty;
  int                      errors;
  int                      pending;

  logic               phase_en  [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  logic [CAP_W-1:0]   phase_cap [PHASES] = '{5'd16, 5'd3, 5'd1, 5'd5, 5'd31, 5'd0, 5'd8, 5'd16};
  logic [SHIFT_W-1:0] phase_sh  [PHASES] = '{4'd6, 4'd0, 4'd12, 4'd6, 4'd15, 4'd4, 4'd6, 4'd3};
  int                 phase_len [PHASES] = '{220, 200, 200, 100, 220, 200, 260, 250};

  logic [47:0]        line_pool [POOL_LINES];
  logic [SHIFT_W-1:0] cur_shift = SHIFT_RESET;
  bit                 calm = 1'b0;
  int                 hold_asked = 0;
  int                 hold_seen = 0;
  int                 quiet_cycles = 0;

  victim_cache_lru_table_core dut (.*);

  victim_cache_lru_table_checker checker_i (.*);

  initial forever #1 clk = ~clk;

  initial begin
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 10);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("victim_cache_lru_table_core verification failed");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] m, input logic c, input logic [47:0] a,
                      input logic d);
    in_valid <= 1'b1;
    mode     <= m;
    core     <= c;
    addr     <= a;
    dirty    <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_regs(input logic en, input logic [CAP_W-1:0] cap,
                          input logic [SHIFT_W-1:0] sh);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(negedge clk);
    cfg_index <= CFG_ENABLE;
    cfg_data  <= CFG_DATA_W'(en);
    @(negedge clk);
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= CFG_DATA_W'(cap);
    @(negedge clk);
    cfg_index <= CFG_OFFSET_BITS;
    cfg_data  <= CFG_DATA_W'(sh);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_shift = sh;
  endtask

  function automatic logic [47:0] pick_addr();
    logic [47:0] low_mask;
    if ($urandom_range(99) < 8) return 48'({$urandom, $urandom});
    low_mask = ($urandom_range(99) < 15) ? 48'h7fff : (48'd1 << cur_shift) - 48'd1;
    return (line_pool[$urandom_range(POOL_LINES - 1)] & ~low_mask) |
           (48'($urandom) & low_mask);
  endfunction

  initial begin
    int roll;
    for (int i = 0; i < POOL_LINES; i++) line_pool[i] = 48'({$urandom, $urandom});
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // disabled after reset: answer zeros, keep nothing
    send(MODE_INSTALL, 1'b0, LINE_A, 1'b1);
    send(MODE_TAKE, 1'b0, LINE_A, 1'b0);
    drain();
    set_regs(1'b1, 5'd2, 4'd6);

    send(MODE_INSTALL, 1'b0, LINE_A, 1'b1);
    send(MODE_INSTALL, 1'b0, LINE_A | 48'h3f, 1'b0);
    send(MODE_INSTALL, 1'b0, LINE_B, 1'b0);
    send(MODE_PEEK, 1'b0, LINE_C, 1'b0);
    send(MODE_PEEK, 1'b0, LINE_B, 1'b0);
    send(MODE_INSTALL, 1'b0, LINE_C, 1'b1);
    send(MODE_TAKE, 1'b0, LINE_B | 48'h11, 1'b0);
    send(MODE_TAKE, 1'b0, LINE_B, 1'b1);
    send(MODE_INSTALL, 1'b1, 48'h0, 1'b0);
    send(MODE_INSTALL, 1'b1, '1, 1'b1);
    send(MODE_PEEK, 1'b1, LINE_A, 1'b0);
    send(MODE_TAKE, 1'b1, '1, 1'b0);
    send(MODE_CLEAR, 1'b1, '1, 1'b1);
    send(MODE_TAKE, 1'b1, 48'h0, 1'b0);
    send(MODE_CLEAR, 1'b0, 48'h0, 1'b0);
    send(MODE_PEEK, 1'b0, LINE_C, 1'b0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      set_regs(phase_en[p], phase_cap[p], phase_sh[p]);
      calm = (p == 6);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 0 && n == 40) hold_asked++;
        if (!calm && $urandom_range(99) < 10) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        roll = $urandom_range(99);
        send(roll < 28 ? MODE_TAKE : roll < 48 ? MODE_PEEK :
             roll < 95 ? MODE_INSTALL : MODE_CLEAR,
             1'($urandom), pick_addr(), 1'($urandom));
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (errors == 0) $display("victim_cache_lru_table_core verification clean");
    else $display("victim_cache_lru_table_core verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/vclru_pkg.sv
hdl/vclru_ctrl.sv
hdl/vclru_dp.sv
hdl/victim_cache_lru_table_core.sv
sim/victim_cache_lru_table_checker.sv
sim/tb_victim_cache_lru_table_core.sv
